// ===== src/env_sensor_compensation_unit_assert.svh =====
// Assertion macros shared by the compensation unit's checking code.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// Whenever the antecedent holds on a clock edge, the consequent must hold on the same edge.
`define ESCU_IMPLIES(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold on the next edge.
`define ESCU_IMPLIES_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/escu_pkg.sv =====
// Shared constants, types and helper functions of the compensation unit.
`timescale 1ns / 1ps
package escu_pkg;

  // Field widths of the channels.
  localparam int RawTempW  = 20;
  localparam int RawPressW = 20;
  localparam int RawHumW   = 16;
  localparam int TempW     = 15;
  localparam int PressW    = 32;
  localparam int HumW      = 17;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  // Calibration register indexes.
  localparam logic [CfgIdxW-1:0] REG_CAL_TEMP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CAL_PRESS_LOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CAL_PRESS_HI  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CAL_P9_HUM    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CAL_H4_H5     = 3'd4;

  // Queue between the front and the back; the depth is a power of two.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One quotient bit per divider stage.
  localparam int DivSteps = 32;

  // Formula constants.
  localparam logic signed [31:0] TEMP_LO    = -32'sd4000;
  localparam logic signed [31:0] TEMP_HI    = 32'sd8500;
  localparam logic signed [31:0] TEMP_RND   = 32'sd128;
  localparam logic signed [31:0] FINE_P_OFS = 32'sd64000;
  localparam logic signed [31:0] FINE_H_OFS = 32'sd76800;
  localparam logic signed [31:0] P1_BIAS    = 32'sd32768;
  localparam logic [31:0]        P_BASE     = 32'd1048576;
  localparam logic [31:0]        P_SCALE    = 32'd3125;
  localparam logic signed [31:0] HUM_RND_E  = 32'sd16384;
  localparam logic signed [31:0] HUM_BIAS_C = 32'sd32768;
  localparam logic signed [31:0] HUM_OFS    = 32'sd2097152;
  localparam logic signed [31:0] HUM_RND_B  = 32'sd8192;
  localparam logic signed [31:0] HV_MAX     = 32'sd419430400;
  localparam logic signed [31:0] HUM_MAX_S  = 32'sd102400;
  localparam logic [HumW-1:0]    HUM_MAX    = 17'd102400;

  // Calibration words as written.
  typedef struct packed {
    logic [23:0] h4_h5;
    logic [55:0] p9_hum;
    logic [63:0] press_hi;
    logic [63:0] press_lo;
    logic [47:0] temp;
  } cal_t;

  // Request as it sits in the queue, with the first temperature terms formed.
  typedef struct packed {
    logic signed [31:0]   ta;
    logic signed [31:0]   tb;
    logic [RawPressW-1:0] adc_p;
    logic [RawHumW-1:0]   adc_h;
  } item_t;

  // Results that ride alongside the pressure division.
  typedef struct packed {
    logic [TempW-1:0]   temp;
    logic signed [31:0] hc;
    logic signed [31:0] hsq;
  } side_t;

  // One divider stage: dvd holds the remaining dividend bits and the quotient so far.
  typedef struct packed {
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic        dbl;
    logic        inv;
    side_t       side;
  } div_t;

  // Signed division by 2**k that truncates toward zero.
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input logic [4:0] k);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return $signed({{16{v[15]}}, v});
  endfunction

  function automatic logic signed [31:0] sx12(input logic [11:0] v);
    return $signed({{20{v[11]}}, v});
  endfunction

  function automatic logic signed [31:0] sx8(input logic [7:0] v);
    return $signed({{24{v[7]}}, v});
  endfunction

endpackage

// ===== src/escu_if.sv =====
// Channel interfaces of the compensation unit: reading, result and calibration write.
`timescale 1ns / 1ps
interface escu_in_if import escu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RawTempW-1:0]  raw_temperature;
  logic [RawPressW-1:0] raw_pressure;
  logic [RawHumW-1:0]   raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface escu_out_if import escu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_centi;
  logic [PressW-1:0]       pressure_pa;
  logic [HumW-1:0]         humidity_q10;
  logic                    pressure_invalid;

  modport source (output valid, temperature_centi, pressure_pa, humidity_q10,
                  pressure_invalid, input ready);
  modport sink (input valid, temperature_centi, pressure_pa, humidity_q10,
                pressure_invalid, output ready);
endinterface

interface escu_cfg_if import escu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/escu_front.sv =====
// Front end: calibration registers and request intake into the queue.
`timescale 1ns / 1ps
module escu_front import escu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  escu_in_if.sink    in_ch,
  escu_cfg_if.sink   cfg_ch,
  output cal_t       cal,
  output logic       push_valid,
  output item_t      push_item,
  input  logic       push_ready
);

  cal_t        cal_r, cal_nxt;
  logic [15:0] t1;

  // Register writes; an unknown index is dropped.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CAL_TEMP:      cal_nxt.temp     = cfg_ch.data[47:0];
        REG_CAL_PRESS_LOW: cal_nxt.press_lo = cfg_ch.data;
        REG_CAL_PRESS_HI:  cal_nxt.press_hi = cfg_ch.data;
        REG_CAL_P9_HUM:    cal_nxt.p9_hum   = cfg_ch.data[55:0];
        REG_CAL_H4_H5:     cal_nxt.h4_h5    = cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign cal          = cal_r;

  // The first temperature terms need only adds, so they are formed on the way in.
  assign t1 = cal_r.temp[15:0];
  assign push_item.ta = $signed({15'd0, in_ch.raw_temperature[19:3]})
                      - $signed({15'd0, t1, 1'b0});
  assign push_item.tb = $signed({16'd0, in_ch.raw_temperature[19:4]})
                      - $signed({16'd0, t1});
  assign push_item.adc_p = in_ch.raw_pressure;
  assign push_item.adc_h = in_ch.raw_humidity;
  assign push_valid      = in_ch.valid;
  assign in_ch.ready     = push_ready;

endmodule

// ===== src/escu_fifo.sv =====
// Short request queue between the front end and the compute pipeline.
`timescale 1ns / 1ps
module escu_fifo import escu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  item_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != QCntW'(QDepth);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCntW'(1);
      2'b01:   cnt_nxt = cnt_r - QCntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/escu_divider.sv =====
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module escu_divider import escu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic        vld_r   [DivSteps];
  logic        vld_nxt [DivSteps];
  div_t        dat_r   [DivSteps];
  div_t        dat_nxt [DivSteps];
  logic [31:0] rem_r   [DivSteps];
  logic [31:0] rem_nxt [DivSteps];

  genvar g;
  for (g = 0; g < DivSteps; g++) begin : g_step
    logic        src_v;
    div_t        src;
    logic [31:0] rem_src;
    logic [32:0] sh, diff;

    if (g == 0) begin : g_first
      assign src_v   = in_valid;
      assign src     = in_data;
      assign rem_src = '0;
    end else begin : g_rest
      assign src_v   = vld_r[g-1];
      assign src     = dat_r[g-1];
      assign rem_src = rem_r[g-1];
    end

    // Bring down the next dividend bit and subtract when it fits.
    assign sh          = {rem_src, src.dvd[31]};
    assign diff        = sh - {1'b0, src.dvs};
    assign rem_nxt[g]  = diff[32] ? sh[31:0] : diff[31:0];
    assign vld_nxt[g]  = src_v;
    assign dat_nxt[g]  = '{dvd: {src.dvd[30:0], ~diff[32]}, dvs: src.dvs, dbl: src.dbl,
                           inv: src.inv, side: src.side};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivSteps; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      for (int i = 0; i < DivSteps; i++) begin
        vld_r[i] <= vld_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DivSteps; i++) begin
        dat_r[i] <= dat_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign out_valid = vld_r[DivSteps-1];
  assign out_data  = dat_r[DivSteps-1];

endmodule

// ===== src/escu_back.sv =====
// Back end: compensation pipeline for temperature, pressure and humidity.
`timescale 1ns / 1ps
module escu_back import escu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cal_t       cal,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_ready,
  escu_out_if.source out_ch
);

  // Calibration fields, extended to 32 bits.
  logic signed [31:0] t2, t3;
  logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t2 = sx16(cal.temp[31:16]);
  assign t3 = sx16(cal.temp[47:32]);
  assign p1 = $signed({16'd0, cal.press_lo[15:0]});
  assign p2 = sx16(cal.press_lo[31:16]);
  assign p3 = sx16(cal.press_lo[47:32]);
  assign p4 = sx16(cal.press_lo[63:48]);
  assign p5 = sx16(cal.press_hi[15:0]);
  assign p6 = sx16(cal.press_hi[31:16]);
  assign p7 = sx16(cal.press_hi[47:32]);
  assign p8 = sx16(cal.press_hi[63:48]);
  assign p9 = sx16(cal.p9_hum[15:0]);
  assign h1 = $signed({24'd0, cal.p9_hum[23:16]});
  assign h2 = sx16(cal.p9_hum[39:24]);
  assign h3 = $signed({24'd0, cal.p9_hum[47:40]});
  assign h6 = sx8(cal.p9_hum[55:48]);
  assign h4 = sx12(cal.h4_h5[11:0]);
  assign h5 = sx12(cal.h4_h5[23:12]);

  // The whole pipeline moves whenever the output register is free or being taken.
  logic adv;
  logic out_valid_r;
  assign adv     = !out_valid_r || out_ch.ready;
  assign q_ready = adv;

  // Valid bits of the stages ahead of the divider, oldest at the top.
  logic [8:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[7:0], q_valid};

  // Stage registers.
  logic signed [31:0]   s2_am_r, s2_bb_r;
  logic signed [31:0]   s3_a1_r, s3_m_r;
  logic signed [31:0]   s4_fine_r;
  logic signed [31:0]   s5_pa_r, s5_ha_r;
  logic [TempW-1:0]     s5_temp_r, s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r;
  logic signed [31:0]   s6_sq_r, s6_ap5_r, s6_p2a_r, s6_hd_r, s6_h6a_r, s6_h3a_r;
  logic signed [31:0]   s7_bm_r, s7_c_r, s7_ap5_r, s7_p2a_r, s7_e_r, s7_hp_r;
  logic signed [31:0]   s8_b_r, s8_x_r, s8_dm_r, s8_e_r;
  logic [31:0]          s9_dvs_r, s9_num_r;
  logic signed [31:0]   s9_c_r;
  div_t                 s10_div_r;
  logic [RawPressW-1:0] s2_p_r, s3_p_r, s4_p_r, s5_p_r, s6_p_r, s7_p_r, s8_p_r;
  logic [RawHumW-1:0]   s2_h_r, s3_h_r, s4_h_r, s5_h_r, s6_h_r;

  // Next values.
  logic signed [31:0] s2_am_nxt, s2_bb_nxt, s3_a1_nxt, s3_m_nxt, s4_fine_nxt;
  logic signed [31:0] t32, tclamp, s5_pa_nxt, s5_ha_nxt, pq;
  logic [TempW-1:0]   s5_temp_nxt;
  logic signed [31:0] s6_sq_nxt, s6_ap5_nxt, s6_p2a_nxt, s6_hd_nxt, s6_h6a_nxt, s6_h3a_nxt;
  logic signed [31:0] hb, hc, s7_bm_nxt, s7_c_nxt, s7_e_nxt, s7_hp_nxt;
  logic signed [31:0] bsum, pa8, hd8, s8_b_nxt, s8_x_nxt, s8_dm_nxt;
  logic [31:0]        pnum, s9_num_nxt, s9_dvs_nxt;
  logic signed [31:0] s9_c_nxt, cq;
  div_t               s10_div_nxt;

  // Temperature, then the first pressure and humidity terms.
  always_comb begin
    s2_am_nxt   = q_item.ta * t2;
    s2_bb_nxt   = q_item.tb * q_item.tb;
    s3_a1_nxt   = sdiv_p2(s2_am_r, 5'd11);
    s3_m_nxt    = sdiv_p2(s2_bb_r, 5'd12) * t3;
    s4_fine_nxt = s3_a1_r + sdiv_p2(s3_m_r, 5'd14);

    t32 = sdiv_p2(s4_fine_r + (s4_fine_r <<< 2) + TEMP_RND, 5'd8);
    if (t32 < TEMP_LO) begin
      tclamp = TEMP_LO;
    end else if (t32 > TEMP_HI) begin
      tclamp = TEMP_HI;
    end else begin
      tclamp = t32;
    end
    s5_temp_nxt = tclamp[TempW-1:0];
    s5_pa_nxt   = (s4_fine_r >>> 1) - FINE_P_OFS;
    s5_ha_nxt   = s4_fine_r - FINE_H_OFS;

    pq         = s5_pa_r >>> 2;
    s6_sq_nxt  = pq * pq;
    s6_ap5_nxt = s5_pa_r * p5;
    s6_p2a_nxt = p2 * s5_pa_r;
    s6_hd_nxt  = h5 * s5_ha_r;
    s6_h6a_nxt = s5_ha_r * h6;
    s6_h3a_nxt = s5_ha_r * h3;
  end

  // Middle pressure and humidity terms.
  always_comb begin
    s7_bm_nxt = (s6_sq_r >>> 11) * p6;
    s7_c_nxt  = p3 * (s6_sq_r >>> 13);
    hb        = $signed({2'd0, s6_h_r, 14'd0});
    hc        = h4 <<< 20;
    s7_e_nxt  = sdiv_p2(hb - hc - s6_hd_r + HUM_RND_E, 5'd15);
    s7_hp_nxt = sdiv_p2(s6_h6a_r, 5'd10) * (sdiv_p2(s6_h3a_r, 5'd11) + HUM_BIAS_C);

    bsum      = s7_bm_r + (s7_ap5_r <<< 1);
    s8_b_nxt  = (bsum >>> 2) + (p4 <<< 16);
    pa8       = ((s7_c_r >>> 3) + (s7_p2a_r >>> 1)) >>> 18;
    s8_x_nxt  = (P1_BIAS + pa8) * p1;
    hd8       = sdiv_p2(s7_hp_r, 5'd10) + HUM_OFS;
    s8_dm_nxt = hd8 * h2;

    s9_dvs_nxt = $unsigned(s8_x_r >>> 15);
    pnum       = P_BASE - {12'd0, s8_p_r} - $unsigned(s8_b_r >>> 12);
    s9_num_nxt = pnum * P_SCALE;
    s9_c_nxt   = s8_e_r * sdiv_p2(s8_dm_r + HUM_RND_B, 5'd14);

    // Divider request: large numerators divide first and double afterwards.
    cq                     = sdiv_p2(s9_c_r, 5'd15);
    s10_div_nxt.dvd        = s9_num_r[31] ? s9_num_r : {s9_num_r[30:0], 1'b0};
    s10_div_nxt.dvs        = s9_dvs_r;
    s10_div_nxt.dbl        = s9_num_r[31];
    s10_div_nxt.inv        = s9_dvs_r == '0;
    s10_div_nxt.side.temp  = s9_temp_r;
    s10_div_nxt.side.hc    = s9_c_r;
    s10_div_nxt.side.hsq   = cq * cq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_am_r   <= s2_am_nxt;
      s2_bb_r   <= s2_bb_nxt;
      s2_p_r    <= q_item.adc_p;
      s2_h_r    <= q_item.adc_h;
      s3_a1_r   <= s3_a1_nxt;
      s3_m_r    <= s3_m_nxt;
      s3_p_r    <= s2_p_r;
      s3_h_r    <= s2_h_r;
      s4_fine_r <= s4_fine_nxt;
      s4_p_r    <= s3_p_r;
      s4_h_r    <= s3_h_r;
      s5_temp_r <= s5_temp_nxt;
      s5_pa_r   <= s5_pa_nxt;
      s5_ha_r   <= s5_ha_nxt;
      s5_p_r    <= s4_p_r;
      s5_h_r    <= s4_h_r;
      s6_sq_r   <= s6_sq_nxt;
      s6_ap5_r  <= s6_ap5_nxt;
      s6_p2a_r  <= s6_p2a_nxt;
      s6_hd_r   <= s6_hd_nxt;
      s6_h6a_r  <= s6_h6a_nxt;
      s6_h3a_r  <= s6_h3a_nxt;
      s6_temp_r <= s5_temp_r;
      s6_p_r    <= s5_p_r;
      s6_h_r    <= s5_h_r;
      s7_bm_r   <= s7_bm_nxt;
      s7_c_r    <= s7_c_nxt;
      s7_ap5_r  <= s6_ap5_r;
      s7_p2a_r  <= s6_p2a_r;
      s7_e_r    <= s7_e_nxt;
      s7_hp_r   <= s7_hp_nxt;
      s7_temp_r <= s6_temp_r;
      s7_p_r    <= s6_p_r;
      s8_b_r    <= s8_b_nxt;
      s8_x_r    <= s8_x_nxt;
      s8_dm_r   <= s8_dm_nxt;
      s8_e_r    <= s7_e_r;
      s8_temp_r <= s7_temp_r;
      s8_p_r    <= s7_p_r;
      s9_dvs_r  <= s9_dvs_nxt;
      s9_num_r  <= s9_num_nxt;
      s9_c_r    <= s9_c_nxt;
      s9_temp_r <= s8_temp_r;
      s10_div_r <= s10_div_nxt;
    end
  end

  // Pressure division.
  logic div_valid;
  div_t div_data;

  escu_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vld_r[8]),
    .in_data   (s10_div_r),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Pressure correction and humidity finish after the divider.
  logic [1:0]         pv_r, pv_nxt;
  logic [31:0]        r1_p_r, r1_pp_r, r2_p_r;
  logic signed [31:0] r1_pd_r, r1_hc_r, r1_dh1_r, r2_c_r, r2_d_r;
  logic               r1_inv_r, r2_inv_r;
  logic [TempW-1:0]   r1_temp_r, r2_temp_r;
  logic [HumW-1:0]    r2_hum_r;

  logic [31:0]        pdq, p3v, r1_pp_nxt;
  logic signed [31:0] r1_pd_nxt, r1_dh1_nxt, r2_c_nxt, hv, hum32, pe;
  logic [HumW-1:0]    r2_hum_nxt;
  logic [PressW-1:0]  press_nxt;

  assign pv_nxt = {pv_r[0], div_valid};

  always_comb begin
    pdq        = div_data.dbl ? {div_data.dvd[30:0], 1'b0} : div_data.dvd;
    p3v        = {3'd0, pdq[31:3]};
    r1_pp_nxt  = p3v * p3v;
    r1_pd_nxt  = $signed({2'd0, pdq[31:2]}) * p8;
    r1_dh1_nxt = sdiv_p2(div_data.side.hsq, 5'd7) * h1;

    r2_c_nxt = p9 * $signed({13'd0, r1_pp_r[31:13]});
    hv       = r1_hc_r - sdiv_p2(r1_dh1_r, 5'd4);
    if (hv < 32'sd0) begin
      hv = 32'sd0;
    end
    if (hv > HV_MAX) begin
      hv = HV_MAX;
    end
    hum32      = hv >>> 12;
    r2_hum_nxt = (hum32 > HUM_MAX_S) ? HUM_MAX : hum32[HumW-1:0];

    pe        = ((r2_c_r >>> 12) + r2_d_r + p7) >>> 4;
    press_nxt = r2_inv_r ? '0 : r2_p_r + $unsigned(pe);
  end

  logic [TempW-1:0]  out_temp_r;
  logic [PressW-1:0] out_press_r;
  logic [HumW-1:0]   out_hum_r;
  logic              out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pv_r        <= pv_nxt;
      out_valid_r <= pv_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_p_r      <= pdq;
      r1_pp_r     <= r1_pp_nxt;
      r1_pd_r     <= r1_pd_nxt;
      r1_hc_r     <= div_data.side.hc;
      r1_dh1_r    <= r1_dh1_nxt;
      r1_inv_r    <= div_data.inv;
      r1_temp_r   <= div_data.side.temp;
      r2_p_r      <= r1_p_r;
      r2_c_r      <= r2_c_nxt;
      r2_d_r      <= r1_pd_r >>> 13;
      r2_inv_r    <= r1_inv_r;
      r2_temp_r   <= r1_temp_r;
      r2_hum_r    <= r2_hum_nxt;
      out_temp_r  <= r2_temp_r;
      out_press_r <= press_nxt;
      out_hum_r   <= r2_hum_r;
      out_inv_r   <= r2_inv_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = $signed(out_temp_r);
  assign out_ch.pressure_pa       = out_press_r;
  assign out_ch.humidity_q10      = out_hum_r;
  assign out_ch.pressure_invalid  = out_inv_r;

endmodule

// ===== src/env_sensor_compensation_unit.sv =====
// Top level of the environmental sensor compensation unit.
//
//  Channel   Direction  Carries
//  in_ch     sink       raw temperature, pressure and humidity reading
//  out_ch    source     temperature, pressure, humidity and invalid flag
//  cfg_ch    sink       calibration register index and write data
//
// One request is accepted per cycle when nothing stalls; a result passes through the
// 32-stage pressure divider plus 12 arithmetic stages.
// Reset (rst_n low, synchronous) clears calibration to zero and empties the pipeline.
// The compute pipeline advances as a whole and halts while a result waits on out_ch;
// the two-entry queue behind the front end keeps taking requests until it fills.
// Calibration writes are taken every cycle.
`timescale 1ns / 1ps
`include "env_sensor_compensation_unit_assert.svh"
module env_sensor_compensation_unit import escu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  escu_in_if.sink    in_ch,
  escu_out_if.source out_ch,
  escu_cfg_if.sink   cfg_ch
);

  cal_t  cal;
  logic  push_valid, push_ready;
  item_t push_item;
  logic  q_valid, q_ready;
  item_t q_item;

  escu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .cal        (cal),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  escu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  escu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

  // An invalid pressure is always reported as zero.
  `ESCU_IMPLIES(a_inv_zero, clk, rst_n, out_ch.valid && out_ch.pressure_invalid, out_ch.pressure_pa == 32'd0, "invalid pressure not zero")
  // Temperature stays inside its clamp limits.
  `ESCU_IMPLIES(a_temp_range, clk, rst_n, out_ch.valid, ($signed(out_ch.temperature_centi) >= -15'sd4000) && ($signed(out_ch.temperature_centi) <= 15'sd8500), "temperature out of range")
  // Humidity stays inside its clamp limit.
  `ESCU_IMPLIES(a_hum_range, clk, rst_n, out_ch.valid, out_ch.humidity_q10 <= 17'd102400, "humidity out of range")
  // A request accepted while the queue is empty is at its head next cycle.
  `ESCU_IMPLIES_NEXT(a_queue_fill, clk, rst_n, push_valid && push_ready && !q_valid, q_valid, "queue lost a request")

endmodule
